[rtl/wavelength_to_rgb_color_assert.svh]
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef WAVELENGTH_TO_RGB_COLOR_ASSERT_SVH
`define WAVELENGTH_TO_RGB_COLOR_ASSERT_SVH

// same-cycle implication
`define WTR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WTR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/wtr_pkg.sv]
package wtr_pkg;

    localparam int WL_W   = 14;
    localparam int CH_W   = 8;
    localparam int Q_W    = 17;    // q1.16, 65536 is 1.0
    localparam int X_W    = 30;    // scaled dividend
    localparam int DEN_W  = 14;
    localparam int RCP_W  = 24;
    localparam int PADDR_W = 3;

    localparam int GAMMA_HUNDREDTHS_DEF = 80;
    localparam int GAMMA_TABLE_BITS_DEF = 10;

    localparam logic [Q_W-1:0]  ONE_Q16    = 17'd65536;
    localparam logic [CH_W-1:0] PEAK_RESET = 8'd255;

    // register index taken from paddr[2]
    localparam logic REG_IDX_PEAK = 1'b0;

    // segment edges in 1/16 nm
    localparam logic [WL_W-1:0] WL_380 = 14'd6080;
    localparam logic [WL_W-1:0] WL_420 = 14'd6720;
    localparam logic [WL_W-1:0] WL_440 = 14'd7040;
    localparam logic [WL_W-1:0] WL_490 = 14'd7840;
    localparam logic [WL_W-1:0] WL_510 = 14'd8160;
    localparam logic [WL_W-1:0] WL_580 = 14'd9280;
    localparam logic [WL_W-1:0] WL_645 = 14'd10320;
    localparam logic [WL_W-1:0] WL_701 = 14'd11216;
    localparam logic [WL_W-1:0] WL_781 = 14'd12496;

    typedef enum logic [2:0] {
        DEN_960,
        DEN_800,
        DEN_320,
        DEN_1120,
        DEN_1040,
        DEN_6400,
        DEN_12800
    } t_den;

    typedef enum logic [1:0] {
        CH_ZERO,
        CH_ONE,
        CH_RATIO
    } t_chsel;

    typedef struct packed {
        t_chsel sel_r;
        t_chsel sel_g;
        t_chsel sel_b;
        logic   f_one;
    } t_side;

    typedef struct packed {
        logic [X_W-1:0] x_c;
        t_den           den_c;
        logic [X_W-1:0] x_f;
        t_den           den_f;
        t_side          side;
    } t_dec;

    function automatic logic [DEN_W-1:0] den_value(input t_den d);
        logic [DEN_W-1:0] v;
        unique case (d)
            DEN_960:   v = 14'd960;
            DEN_800:   v = 14'd800;
            DEN_320:   v = 14'd320;
            DEN_1120:  v = 14'd1120;
            DEN_1040:  v = 14'd1040;
            DEN_6400:  v = 14'd6400;
            DEN_12800: v = 14'd12800;
            default:   v = 14'd12800;
        endcase
        return v;
    endfunction

    // floor(2^32 / den)
    function automatic logic [RCP_W-1:0] den_recip(input t_den d);
        logic [RCP_W-1:0] v;
        unique case (d)
            DEN_960:   v = 24'd4473924;
            DEN_800:   v = 24'd5368709;
            DEN_320:   v = 24'd13421772;
            DEN_1120:  v = 24'd3834792;
            DEN_1040:  v = 24'd4129776;
            DEN_6400:  v = 24'd671088;
            DEN_12800: v = 24'd335544;
            default:   v = 24'd335544;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bit_m;
        logic        started;
        v = v_in;
        r = 64'd0;
        started = 1'b0;
        for (int j = 31; j >= 0; j--) begin
            bit_m = 64'd1 << (2 * j);
            if (!started && bit_m <= v)
                started = 1'b1;
            if (started) begin
                if (v >= r + bit_m) begin
                    v = v - (r + bit_m);
                    r = (r >> 1) + bit_m;
                end else begin
                    r = r >> 1;
                end
            end
        end
        return r;
    endfunction

    // x^(hundredths/100) for x = idx / 2^tbits, q1.16, elaboration only
    function automatic logic [Q_W-1:0] gamma_entry(input int unsigned idx,
                                                   input int unsigned hundredths,
                                                   input int unsigned tbits);
        logic [63:0] root [16];
        logic [63:0] m;
        logic [63:0] neg;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] res;
        int unsigned e;
        int unsigned frac;
        int unsigned n;
        int unsigned f;
        if (idx == 0)
            return '0;
        root[0] = isqrt64(64'd1 << 59);
        for (int k = 1; k < 16; k++)
            root[k] = isqrt64(root[k-1] << 30);
        e = 0;
        for (int k = 0; k < 31; k++)
            if ((idx >> (k + 1)) != 0)
                e = k + 1;
        m = 64'(idx) << (30 - e);
        frac = 0;
        // log2 mantissa bits by repeated squaring
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        neg = 64'(tbits - e) * 64'd65536 - 64'(frac);
        t = (neg * 64'(hundredths) + 64'd50) / 64'd100;
        n = 32'(t >> 16);
        f = 32'(t & 64'hFFFF);
        p = 64'd1 << 30;
        for (int k = 0; k < 16; k++)
            if (((f >> (15 - k)) & 1) != 0)
                p = (p * root[k] + (64'd1 << 29)) >> 30;
        if (n + 14 >= 31)
            res = 64'd0;
        else
            res = (p + (64'd1 << (13 + n))) >> (14 + n);
        return res[Q_W-1:0];
    endfunction

endpackage

[rtl/wtr_decode.sv]
module wtr_decode
    import wtr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [WL_W-1:0] i_wavelength,
    output logic            o_valid,
    output t_dec            o_dec
);

    logic [10:0]     num_c;
    logic [WL_W-1:0] num_f;
    t_dec            n_dec;
    t_dec            r_dec;
    logic            r_valid;

    always_comb begin
        num_c = '0;
        num_f = '0;
        n_dec.den_c      = DEN_960;
        n_dec.den_f      = DEN_6400;
        n_dec.side.sel_r = CH_ZERO;
        n_dec.side.sel_g = CH_ZERO;
        n_dec.side.sel_b = CH_ZERO;
        n_dec.side.f_one = 1'b1;

        if (i_wavelength >= WL_380 && i_wavelength < WL_781) begin
            if (i_wavelength < WL_440) begin
                num_c = 11'(WL_440 - i_wavelength);
                n_dec.den_c      = DEN_960;
                n_dec.side.sel_r = CH_RATIO;
                n_dec.side.sel_b = CH_ONE;
            end else if (i_wavelength < WL_490) begin
                num_c = 11'(i_wavelength - WL_440);
                n_dec.den_c      = DEN_800;
                n_dec.side.sel_g = CH_RATIO;
                n_dec.side.sel_b = CH_ONE;
            end else if (i_wavelength < WL_510) begin
                num_c = 11'(WL_510 - i_wavelength);
                n_dec.den_c      = DEN_320;
                n_dec.side.sel_g = CH_ONE;
                n_dec.side.sel_b = CH_RATIO;
            end else if (i_wavelength < WL_580) begin
                num_c = 11'(i_wavelength - WL_510);
                n_dec.den_c      = DEN_1120;
                n_dec.side.sel_r = CH_RATIO;
                n_dec.side.sel_g = CH_ONE;
            end else if (i_wavelength < WL_645) begin
                num_c = 11'(WL_645 - i_wavelength);
                n_dec.den_c      = DEN_1040;
                n_dec.side.sel_r = CH_ONE;
                n_dec.side.sel_g = CH_RATIO;
            end else begin
                n_dec.side.sel_r = CH_ONE;
            end

            // edge falloff: 0.3 + 0.7 * ramp
            if (i_wavelength < WL_420) begin
                num_f = 14'(17'd1920 + 17'd7 * 17'(i_wavelength - WL_380));
                n_dec.den_f      = DEN_6400;
                n_dec.side.f_one = 1'b0;
            end else if (i_wavelength >= WL_701) begin
                // 3840 + 7 * (12480 - w), may dip below 0.3 near the top
                num_f = 14'(17'd91200 - 17'd7 * 17'(i_wavelength));
                n_dec.den_f      = DEN_12800;
                n_dec.side.f_one = 1'b0;
            end
        end

        n_dec.x_c = (X_W'(num_c) << 16) + X_W'(den_value(n_dec.den_c) >> 1);
        n_dec.x_f = (X_W'(num_f) << 16) + X_W'(den_value(n_dec.den_f) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

[rtl/wtr_cdiv.sv]
// rounded quotient by a fixed denominator: reciprocal estimate, back-multiply, fix-up
module wtr_cdiv
    import wtr_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [X_W-1:0] i_x,
    input  t_den           i_den,
    output logic [Q_W-1:0] o_q
);

    logic [X_W+RCP_W-1:0] prod_est;
    logic [X_W-1:0]       rem;

    logic [X_W-1:0]       r_x1;
    t_den                 r_den1;
    logic [Q_W-1:0]       r_qe1;
    logic [X_W-1:0]       r_x2;
    t_den                 r_den2;
    logic [Q_W-1:0]       r_qe2;
    logic [Q_W+DEN_W-1:0] r_qd2;
    logic [Q_W-1:0]       r_q;

    // estimate is the true quotient or one short
    assign prod_est = (X_W+RCP_W)'(i_x) * (X_W+RCP_W)'(den_recip(i_den));
    assign rem      = r_x2 - X_W'(r_qd2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1   <= i_x;
            r_den1 <= i_den;
            r_qe1  <= prod_est[32 +: Q_W];

            r_x2   <= r_x1;
            r_den2 <= r_den1;
            r_qe2  <= r_qe1;
            r_qd2  <= (Q_W+DEN_W)'(r_qe1) * (Q_W+DEN_W)'(den_value(r_den1));

            r_q    <= (rem >= X_W'(den_value(r_den2))) ? r_qe2 + 1'b1 : r_qe2;
        end
    end

    assign o_q = r_q;

endmodule

[rtl/wtr_gamma_rom.sv]
module wtr_gamma_rom
    import wtr_pkg::*;
#(
    parameter int GAMMA_HUNDREDTHS = GAMMA_HUNDREDTHS_DEF,
    parameter int GAMMA_TABLE_BITS = GAMMA_TABLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [GAMMA_TABLE_BITS:0] i_addr,
    output logic [Q_W-1:0]            o_data
);

    localparam int ROM_DEPTH = (1 << GAMMA_TABLE_BITS) + 1;

    typedef logic [Q_W-1:0] t_rom_arr [ROM_DEPTH];

    function automatic t_rom_arr build_rom();
        t_rom_arr tbl;
        for (int i = 0; i < ROM_DEPTH; i++)
            tbl[i] = gamma_entry(i, GAMMA_HUNDREDTHS, GAMMA_TABLE_BITS);
        return tbl;
    endfunction

    localparam t_rom_arr GAMMA_ROM = build_rom();

    logic [Q_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= GAMMA_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

[rtl/wavelength_to_rgb_color.sv]
// an accepted input beat passes through eight pipeline registers (decode, three divider
// steps, level product, rom index, rom read, peak product) and then the output register to o_valid
// throughput: one beat per cycle while o_ready is high; a two-entry output register and skid
// keep o_ready high while one result waits, and o_ready drops while the skid holds a beat
// reset: synchronous, active low; clears all valid bits and sets r_peak to 255
module wavelength_to_rgb_color
    import wtr_pkg::*;
#(
    parameter int GAMMA_HUNDREDTHS = GAMMA_HUNDREDTHS_DEF,
    parameter int GAMMA_TABLE_BITS = GAMMA_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [WL_W-1:0]    i_wavelength,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CH_W-1:0]    o_red,
    output logic [CH_W-1:0]    o_green,
    output logic [CH_W-1:0]    o_blue,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    `include "wavelength_to_rgb_color_assert.svh"

    localparam int IDX_W     = GAMMA_TABLE_BITS + 1;
    localparam int IDX_SHIFT = 16 - GAMMA_TABLE_BITS;
    localparam int IDX_HALF  = 1 << (15 - GAMMA_TABLE_BITS);
    localparam int IDX_MAX   = 1 << GAMMA_TABLE_BITS;
    localparam int NCH       = 3;

    logic            en;
    logic            take;
    logic [CH_W-1:0] r_peak;

    logic            v1;
    t_dec            dec1;
    logic [Q_W-1:0]  q_c;
    logic [Q_W-1:0]  q_f;

    logic            r_vld2, r_vld3, r_vld4, r_vld5, r_vld6, r_vld7, r_vld8;
    t_side           r_side2, r_side3, r_side4;

    t_chsel          sel4 [NCH];
    logic [Q_W-1:0]  ch4 [NCH];
    logic [Q_W-1:0]  f4;

    logic [2*Q_W-2:0] r_prod5 [NCH];
    logic [Q_W-1:0]   lvl5 [NCH];
    logic [IDX_W-1:0] r_idx6 [NCH];
    logic [Q_W-1:0]   rom7 [NCH];
    logic [24:0]      r_prod8 [NCH];
    logic [CH_W-1:0]  d8 [NCH];

    logic            r_out_vld;
    logic            r_skid_vld;
    logic [CH_W-1:0] r_out [NCH];
    logic [CH_W-1:0] r_skid [NCH];

    logic            skid_due;
    logic            idx_ok;
    logic            lvl_ok;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_PEAK) ? {24'd0, r_peak} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= PEAK_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_PEAK) begin
            r_peak <= pwdata[CH_W-1:0];
        end
    end

    // ---------------- pipeline ----------------
    assign en      = !r_skid_vld;
    assign o_ready = en;
    assign take    = r_out_vld && i_ready;

    wtr_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_wavelength (i_wavelength),
        .o_valid      (v1),
        .o_dec        (dec1)
    );

    wtr_cdiv u_div_ch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (dec1.x_c),
        .i_den (dec1.den_c),
        .o_q   (q_c)
    );

    wtr_cdiv u_div_edge (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (dec1.x_f),
        .i_den (dec1.den_f),
        .o_q   (q_f)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
            r_vld8 <= 1'b0;
        end else if (en) begin
            r_vld2 <= v1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
            r_vld7 <= r_vld6;
            r_vld8 <= r_vld7;
        end
    end

    // segment selects ride alongside the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side2 <= dec1.side;
            r_side3 <= r_side2;
            r_side4 <= r_side3;
        end
    end

    assign sel4[0] = r_side4.sel_r;
    assign sel4[1] = r_side4.sel_g;
    assign sel4[2] = r_side4.sel_b;
    assign f4      = r_side4.f_one ? ONE_Q16 : q_f;

    for (genvar c = 0; c < NCH; c++) begin : g_ch
        always_comb begin
            case (sel4[c])
                CH_ONE:   ch4[c] = ONE_Q16;
                CH_RATIO: ch4[c] = q_c;
                default:  ch4[c] = '0;
            endcase
        end

        // level and rom index, both rounded half up
        assign lvl5[c] = Q_W'((r_prod5[c] + (2*Q_W-1)'(32768)) >> 16);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_prod5[c] <= (2*Q_W-1)'(ch4[c]) * (2*Q_W-1)'(f4);
                r_idx6[c]  <= IDX_W'(((Q_W+1)'(lvl5[c]) + (Q_W+1)'(IDX_HALF)) >> IDX_SHIFT);
                r_prod8[c] <= 25'(r_peak) * 25'(rom7[c]);
            end
        end

        wtr_gamma_rom #(
            .GAMMA_HUNDREDTHS (GAMMA_HUNDREDTHS),
            .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
        ) u_rom (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_addr (r_idx6[c]),
            .o_data (rom7[c])
        );

        assign d8[c] = CH_W'((r_prod8[c] + 25'd32768) >> 16);
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take)
                r_skid_vld <= 1'b0;
        end else if (r_vld8) begin
            if (!r_out_vld || take)
                r_out_vld <= 1'b1;
            else
                r_skid_vld <= 1'b1;
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take)
                r_out <= r_skid;
        end else if (r_vld8) begin
            if (!r_out_vld || take)
                r_out <= d8;
            else
                r_skid <= d8;
        end
    end

    assign o_valid = r_out_vld;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

    // ---------------- checks ----------------
    assign skid_due = r_vld8 && r_out_vld && !i_ready && !r_skid_vld;
    assign idx_ok   = (r_idx6[0] <= IDX_W'(IDX_MAX)) && (r_idx6[1] <= IDX_W'(IDX_MAX))
                   && (r_idx6[2] <= IDX_W'(IDX_MAX));
    assign lvl_ok   = (lvl5[0] <= ONE_Q16) && (lvl5[1] <= ONE_Q16) && (lvl5[2] <= ONE_Q16);

    `WTR_ASSERT_IMP(a_skid_behind_out, r_skid_vld, r_out_vld, "skid holds a beat without output")
    `WTR_ASSERT_NXT(a_skid_fill, skid_due, r_skid_vld, "stalled beat not caught in skid")
    `WTR_ASSERT_IMP(a_idx_range, r_vld6, idx_ok, "gamma index past table end")
    `WTR_ASSERT_IMP(a_level_range, r_vld5, lvl_ok, "channel level above one")

endmodule

[verif/wavelength_to_rgb_color_test.sv]
`timescale 1ns / 100ps

module wavelength_to_rgb_color_test
    import wtr_pkg::*;
();

    localparam int GAMMA_PCT   = 80;
    localparam int CURVE_BITS  = 10;
    localparam int CURVE_SIZE  = (1 << CURVE_BITS) + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 200;
    localparam logic [PADDR_W-1:0] PEAK_ADDR = 3'd0;

    // segment edges in 1/16 nm
    localparam int unsigned NM_380 = 6080;
    localparam int unsigned NM_420 = 6720;
    localparam int unsigned NM_440 = 7040;
    localparam int unsigned NM_490 = 7840;
    localparam int unsigned NM_510 = 8160;
    localparam int unsigned NM_580 = 9280;
    localparam int unsigned NM_645 = 10320;
    localparam int unsigned NM_701 = 11216;
    localparam int unsigned NM_781 = 12496;
    localparam int unsigned EDGES [9] = '{NM_380, NM_420, NM_440, NM_490, NM_510,
                                          NM_580, NM_645, NM_701, NM_781};

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_color;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [WL_W-1:0]    i_wavelength = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [CH_W-1:0]    o_red;
    logic [CH_W-1:0]    o_green;
    logic [CH_W-1:0]    o_blue;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic [16:0]     gamma_curve [0:CURVE_SIZE-1];
    logic [CH_W-1:0] peak_now;
    t_color          expected_colors [$];
    int              errors = 0;
    int              beats_sent = 0;
    int              colors_checked = 0;
    int              peak_settings = 1;
    int              cycle_count = 0;
    int              rx_stall_pct = 0;
    logic            hold_request = 1'b0;
    logic            rx_hold = 1'b0;

    wavelength_to_rgb_color #(
        .GAMMA_HUNDREDTHS(GAMMA_PCT),
        .GAMMA_TABLE_BITS(CURVE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_wavelength (i_wavelength),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] floor_root64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // x^gamma for x = i / 2^CURVE_BITS, via fixed-point log2 and exp2
    function automatic void build_gamma_curve();
        logic [63:0] roots [16];
        logic [63:0] m;
        logic [63:0] neg;
        logic [63:0] t;
        logic [63:0] p;
        int unsigned e;
        int unsigned frac;
        int unsigned n;
        int unsigned f;
        roots[0] = floor_root64(64'd1 << 59);
        for (int k = 1; k < 16; k++)
            roots[k] = floor_root64(roots[k-1] << 30);
        gamma_curve[0] = '0;
        for (int i = 1; i < CURVE_SIZE; i++) begin
            e = 0;
            while ((i >> (e + 1)) != 0)
                e++;
            m = 64'(i) << (30 - e);
            frac = 0;
            for (int k = 0; k < 16; k++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            neg = 64'(CURVE_BITS - e) * 64'd65536 - 64'(frac);
            t = (neg * 64'(GAMMA_PCT) + 64'd50) / 64'd100;
            n = 32'(t >> 16);
            f = 32'(t & 64'hFFFF);
            p = 64'd1 << 30;
            for (int k = 0; k < 16; k++)
                if (((f >> (15 - k)) & 1) != 0)
                    p = (p * roots[k] + (64'd1 << 29)) >> 30;
            if (n + 14 >= 31)
                gamma_curve[i] = '0;
            else
                gamma_curve[i] = 17'((p + (64'd1 << (13 + n))) >> (14 + n));
        end
    endfunction

    function automatic logic [16:0] ratio_q16(input int unsigned num, input int unsigned den);
        return 17'(((64'(num) << 16) + 64'(den / 2)) / 64'(den));
    endfunction

    function automatic logic [CH_W-1:0] channel_code(input logic [16:0] c, input logic [16:0] f,
                                                     input logic [CH_W-1:0] peak);
        logic [63:0] level;
        logic [63:0] idx;
        logic [63:0] prod;
        level = (64'(c) * 64'(f) + 64'd32768) >> 16;
        idx = (level + (64'd1 << (15 - CURVE_BITS))) >> (16 - CURVE_BITS);
        if (idx >= CURVE_SIZE)
            idx = CURVE_SIZE - 1;
        prod = (64'(peak) * 64'(gamma_curve[idx]) + 64'd32768) >> 16;
        return prod[CH_W-1:0];
    endfunction

    function automatic t_color wavelength_color(input logic [WL_W-1:0] wl,
                                                input logic [CH_W-1:0] peak);
        int unsigned w;
        logic [16:0] r;
        logic [16:0] g;
        logic [16:0] b;
        logic [16:0] f;
        t_color      res;
        w = wl;
        r = '0;
        g = '0;
        b = '0;
        res = '0;
        if (w < NM_380 || w >= NM_781)
            return res;
        if (w < NM_440) begin
            r = ratio_q16(NM_440 - w, 960);
            b = ONE_Q16;
        end else if (w < NM_490) begin
            g = ratio_q16(w - NM_440, 800);
            b = ONE_Q16;
        end else if (w < NM_510) begin
            g = ONE_Q16;
            b = ratio_q16(NM_510 - w, 320);
        end else if (w < NM_580) begin
            r = ratio_q16(w - NM_510, 1120);
            g = ONE_Q16;
        end else if (w < NM_645) begin
            r = ONE_Q16;
            g = ratio_q16(NM_645 - w, 1040);
        end else begin
            r = ONE_Q16;
        end
        // edge falloff, dips a little under 0.3 just below 781 nm
        if (w < NM_420)
            f = ratio_q16(1920 + 7 * (w - NM_380), 6400);
        else if (w < NM_701)
            f = ONE_Q16;
        else
            f = ratio_q16(int'(3840 + 7 * (12480 - int'(w))), 12800);
        res.red   = channel_code(r, f, peak);
        res.green = channel_code(g, f, peak);
        res.blue  = channel_code(b, f, peak);
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // long output hold-off, counted here so the sender keeps pushing meanwhile
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_color want;
        t_color got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{red: o_red, green: o_green, blue: o_blue};
            if (expected_colors.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected color beat %0d/%0d/%0d", $time,
                             got.red, got.green, got.blue);
            end else begin
                want = expected_colors.pop_front();
                colors_checked++;
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: rgb expected %0d/%0d/%0d actual %0d/%0d/%0d",
                                 $time, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("Regression FAIL");
        $finish;
    end

    // call right after a rising edge; gap idles the input after acceptance
    task automatic send_wavelength(input logic [WL_W-1:0] wl, input int gap);
        i_valid <= 1'b1;
        i_wavelength <= wl;
        do @(posedge i_clk); while (!o_ready);
        expected_colors.push_back(wavelength_color(wl, peak_now));
        beats_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        while (expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_peak(input logic [CH_W-1:0] value);
        logic [31:0] word;
        word = $urandom;
        word[CH_W-1:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PEAK_ADDR;
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        peak_now = word[CH_W-1:0];
        peak_settings++;
    endtask

    function automatic logic [WL_W-1:0] pick_wavelength();
        int unsigned sel;
        int          near;
        sel = $urandom_range(99);
        if (sel < 70)
            return WL_W'($urandom_range(NM_781 - 1, NM_380));
        if (sel < 85) begin
            near = int'(EDGES[$urandom_range(8)]) + int'($urandom_range(16)) - 8;
            return WL_W'(near);
        end
        return WL_W'($urandom_range(16383, 0));
    endfunction

    task automatic test_directed();
        logic [WL_W-1:0] points [$];
        points = '{14'd0, 14'd16383, 14'd10922, 14'd5461, 14'd6079, 14'd6080, 14'd6081,
                   14'd6719, 14'd6720, 14'd7039, 14'd7040, 14'd7041, 14'd7839, 14'd7840,
                   14'd8159, 14'd8160, 14'd8161, 14'd9279, 14'd9280, 14'd10319, 14'd10320,
                   14'd11215, 14'd11216, 14'd12480, 14'd12495, 14'd12496};
        foreach (points[k])
            send_wavelength(points[k], 0);
        i_valid <= 1'b0;
    endtask

    task automatic test_random(input int count, input int tx_idle_pct, input int stall_pct);
        int gap;
        rx_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            gap = 0;
            while ($urandom_range(99) < tx_idle_pct)
                gap++;
            send_wavelength(pick_wavelength(), gap);
        end
        i_valid <= 1'b0;
    endtask

    task automatic test_backpressure();
        rx_stall_pct = 0;
        hold_request = 1'b1;
        for (int n = 0; n < 80; n++)
            send_wavelength(pick_wavelength(), 0);
        i_valid <= 1'b0;
    endtask

    initial begin
        build_gamma_curve();
        peak_now = PEAK_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_idle();
        write_peak(8'd255);
        test_random(300, 0, 0);
        wait_idle();
        write_peak(8'd0);
        test_random(300, 61, 0);
        wait_idle();
        write_peak(8'd1);
        test_random(300, 0, 61);
        wait_idle();
        write_peak(8'($urandom_range(254, 2)));
        test_random(300, 10, 10);
        wait_idle();
        write_peak(8'd128);
        test_backpressure();
        wait_idle();

        $display("sent %0d wavelengths, checked %0d colors across %0d peak values",
                 beats_sent, colors_checked, peak_settings);
        $display("random gaps on both sides plus one %0d-cycle output hold", HOLD_CYCLES);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
